FILE: sv/rued_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rued_pkg
// shared types and constants of the rank/unary/escape decoder
// ----------------------------------------------------------------------------
package rued_pkg;

  localparam int COUNT_WIDTH_DEF = 20;   // default width of the symbol counter
  localparam int BYTE_W          = 8;    // code byte and symbol width
  localparam int BLEN_W          = 20;   // block_length register width
  localparam int RANK_COUNT      = 7;    // number of rank symbols
  localparam int RANK_IDX_W      = 3;
  localparam int CFG_IDX_W       = 3;    // eight configuration registers

  localparam logic [RANK_IDX_W-1:0] ESCAPE_RUN     = 3'd7;  // zeros that open a literal
  localparam logic [2:0]            LAST_BIT_POS   = 3'd7;  // last bit of a byte / literal

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 3'd7;  // 0..6 are the rank symbols

  localparam int IN_FIFO_DEPTH  = 4;
  localparam int OUT_FIFO_DEPTH = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic              last_of_byte;
    logic              end_of_block;
  } result_t;

endpackage

FILE: sv/rued_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rued_fifo
// small first-word-fall-through queue, used for code bytes and for results
// ----------------------------------------------------------------------------
module rued_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/rued_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rued_bit_engine
// walks a code bit per cycle unless res_full; holds state, cfg regs, counter
// ----------------------------------------------------------------------------
module rued_bit_engine import rued_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLEN_W-1:0]    cfg_data,
  // code byte queue
  input  logic                 byte_empty,
  input  logic [BYTE_W-1:0]    byte_data,
  output logic                 byte_pop,
  // result queue
  input  logic                 res_full,
  output logic                 res_push,
  output result_t              res_data
);

  localparam int CMP_W = (COUNT_WIDTH > BLEN_W) ? COUNT_WIDTH : BLEN_W;

  logic [BYTE_W-1:0]      rank_r [RANK_COUNT];
  logic [BLEN_W-1:0]      blen_r;

  logic                   busy_r, busy_nxt;
  logic [BYTE_W-1:0]      shift_r, shift_nxt;
  logic [2:0]             pos_r, pos_nxt;
  logic [RANK_IDX_W-1:0]  zero_run_r, zero_run_nxt;
  logic                   in_lit_r, in_lit_nxt;
  logic [2:0]             lit_cnt_r, lit_cnt_nxt;
  logic [BYTE_W-1:0]      lit_val_r, lit_val_nxt;
  logic [COUNT_WIDTH-1:0] done_cnt_r, done_cnt_nxt;

  logic                   adv, bit_in, emit, eob, finish, load;
  logic [BYTE_W-1:0]      sym, lit_merged;
  logic [RANK_IDX_W-1:0]  rank_idx;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [BLEN_W-1:0]      limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RANK_COUNT; i++) begin
        rank_r[i] <= '0;
      end
      blen_r <= BLEN_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_BLOCK_LENGTH) begin
        blen_r <= cfg_data;
      end else begin
        rank_r[cfg_index] <= cfg_data[BYTE_W-1:0];
      end
    end
  end

  // bit walk
  assign adv        = busy_r && !res_full;
  assign bit_in     = shift_r[0];
  assign rank_idx   = (zero_run_r == ESCAPE_RUN) ? '0 : zero_run_r;
  assign lit_merged = lit_val_r | (BYTE_W'(bit_in) << lit_cnt_r);

  // symbol counter, block ends on limit, counter top or wrap
  assign cnt_inc = done_cnt_r + 1'b1;
  assign limit   = (blen_r == '0) ? BLEN_W'(1) : blen_r;
  assign eob     = (CMP_W'(cnt_inc) >= CMP_W'(limit)) || (cnt_inc == '1) || (cnt_inc == '0);

  always_comb begin
    emit         = 1'b0;
    sym          = rank_r[rank_idx];
    zero_run_nxt = zero_run_r;
    in_lit_nxt   = in_lit_r;
    lit_cnt_nxt  = lit_cnt_r;
    lit_val_nxt  = lit_val_r;
    done_cnt_nxt = done_cnt_r;
    if (adv) begin
      if (in_lit_r) begin
        if (lit_cnt_r == LAST_BIT_POS) begin
          emit        = 1'b1;
          sym         = lit_merged;
          in_lit_nxt  = 1'b0;
          lit_cnt_nxt = '0;
          lit_val_nxt = '0;
        end else begin
          lit_val_nxt = lit_merged;
          lit_cnt_nxt = lit_cnt_r + 1'b1;
        end
      end else if (bit_in) begin
        emit         = 1'b1;
        zero_run_nxt = '0;
      end else if (zero_run_r + 1'b1 == ESCAPE_RUN) begin
        zero_run_nxt = '0;
        in_lit_nxt   = 1'b1;
        lit_cnt_nxt  = '0;
        lit_val_nxt  = '0;
      end else begin
        zero_run_nxt = zero_run_r + 1'b1;
      end
      if (emit) begin
        if (eob) begin
          zero_run_nxt = '0;
          in_lit_nxt   = 1'b0;
          lit_cnt_nxt  = '0;
          lit_val_nxt  = '0;
          done_cnt_nxt = '0;
        end else begin
          done_cnt_nxt = cnt_inc;
        end
      end
    end
  end

  // byte ends after its eighth bit or on a block end
  assign finish   = adv && ((pos_r == LAST_BIT_POS) || (emit && eob));
  assign load     = !byte_empty && (!busy_r || finish);
  assign byte_pop = load;

  always_comb begin
    busy_nxt  = busy_r;
    shift_nxt = shift_r;
    pos_nxt   = pos_r;
    if (load) begin
      busy_nxt  = 1'b1;
      shift_nxt = byte_data;
      pos_nxt   = '0;
    end else if (finish) begin
      busy_nxt  = 1'b0;
    end else if (adv) begin
      shift_nxt = shift_r >> 1;
      pos_nxt   = pos_r + 1'b1;
    end
  end

  // after any symbol the decoder is back at a clean run, so a later one in
  // this byte appears exactly when a one bit remains
  assign res_push              = emit;
  assign res_data.symbol       = sym;
  assign res_data.end_of_block = eob;
  assign res_data.last_of_byte = eob || (shift_r[BYTE_W-1:1] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pos_r      <= '0;
      zero_run_r <= '0;
      in_lit_r   <= 1'b0;
      lit_cnt_r  <= '0;
      lit_val_r  <= '0;
      done_cnt_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      pos_r      <= pos_nxt;
      zero_run_r <= zero_run_nxt;
      in_lit_r   <= in_lit_nxt;
      lit_cnt_r  <= lit_cnt_nxt;
      lit_val_r  <= lit_val_nxt;
      done_cnt_r <= done_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

endmodule

FILE: sv/rank_unary_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_unary_escape_decoder
// decodes rank/unary coded bytes with a literal escape into symbols
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: a code byte word is taken when in_push is high and
//   in_full is low; bytes wait in a four-word queue ahead of the decoder
//   result side is a queue too: while out_empty is low the oldest symbol word
//   is on out_symbol / out_last_of_byte / out_end_of_block, and out_pop takes it
//   configuration: cfg_index 0..6 set the rank symbols, 7 the block length;
//   cfg_ready is always high, write only while the block is idle
// timing
//   the decoder walks one code bit per clock unless the result queue is full,
//   so a byte occupies it up to its eighth bit or a block end inside it, while
//   the byte queue keeps taking bytes; up to one symbol per cycle
//   first symbol of a byte reaches the result queue once the walk gets to the
//   bit that ends its code
// reset
//   rst_n (synchronous, low) empties both queues, clears decode state and the
//   symbol count, sets rank symbols to zero and the block length to one
// stalls
//   when the result queue fills the bit walk holds; the byte queue keeps taking
//   words until it is full, then in_full rises
// ----------------------------------------------------------------------------
module rank_unary_escape_decoder import rued_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // code byte channel
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [BYTE_W-1:0]    in_code_byte,
  // result channel
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [BYTE_W-1:0]    out_symbol,
  output logic                 out_last_of_byte,
  output logic                 out_end_of_block,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLEN_W-1:0]    cfg_data
);

  // front: code byte queue
  logic              byte_empty, byte_pop;
  logic [BYTE_W-1:0] byte_data;

  // back to output queue
  logic              res_full, res_push;
  result_t           res_data, res_head;

  rued_fifo #(
    .WIDTH (BYTE_W),
    .DEPTH (IN_FIFO_DEPTH)
  ) u_byte_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_code_byte),
    .full  (in_full),
    .pop   (byte_pop),
    .rdata (byte_data),
    .empty (byte_empty)
  );

  // back: bit-serial decoder with configuration registers and block counter
  rued_bit_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_empty (byte_empty),
    .byte_data  (byte_data),
    .byte_pop   (byte_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  // result queue decouples the bit walk from the receiver
  rued_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_symbol       = res_head.symbol;
  assign out_last_of_byte = res_head.last_of_byte;
  assign out_end_of_block = res_head.end_of_block;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rank/unary/escape decoder: code byte words go in
// through a queue-style driver, a bit-level decoder model inside the bench
// predicts every symbol word, and a monitor checks each popped word in order
// ----------------------------------------------------------------------------
module tb_top;
  import rued_pkg::*;

  localparam int                        COUNT_W        = COUNT_WIDTH_DEF;
  localparam logic [CFG_IDX_W-1:0]      REG_RANK_BASE  = '0;   // rank x sits at base + x
  localparam logic [BLEN_W-1:0]         BLEN_MAX       = '1;
  localparam int                        IDLE_GAP       = 64;   // queued bytes may still yield nothing
  localparam int                        DRAIN_LIMIT    = 20000;
  localparam int                        RX_HOLD_CYCLES = 300;
  localparam int                        PHASE_ITEMS    = 30;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // stimulus side
  logic                 in_push      = 1'b0;
  logic [BYTE_W-1:0]    in_code_byte = '0;
  logic                 out_pop      = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [BLEN_W-1:0]    cfg_data     = '0;

  // block outputs
  logic                 in_full;
  logic                 out_empty;
  logic [BYTE_W-1:0]    out_symbol;
  logic                 out_last_of_byte;
  logic                 out_end_of_block;
  logic                 cfg_ready;

  // bench bookkeeping
  logic [BYTE_W-1:0] pending_bytes[$];   // code bytes waiting to be pushed
  result_t           symbols_due[$];     // predicted symbol words, oldest first
  bit                code_bits[$];       // encoder bit stream, lsb first
  int                mismatch_count = 0;
  int                tx_idle_pct    = 0;
  int                rx_idle_pct    = 0;
  bit                rx_hold_req    = 1'b0;
  bit                rx_hold_done   = 1'b0;
  result_t           want;

  // decoder model state, mirrors the block after reset
  logic [BYTE_W-1:0]  rank_sym [RANK_COUNT] = '{default: '0};
  logic [BLEN_W-1:0]  blk_len   = BLEN_W'(1);
  logic [2:0]         run_len   = '0;
  bit                 lit_active = 1'b0;
  logic [2:0]         lit_pos   = '0;
  logic [BYTE_W-1:0]  lit_acc   = '0;
  logic [COUNT_W-1:0] sym_done  = '0;

  rank_unary_escape_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_code_byte     (in_code_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_symbol       (out_symbol),
    .out_last_of_byte (out_last_of_byte),
    .out_end_of_block (out_end_of_block),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall time limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // walk one code byte bit by bit, lsb first, and queue the symbol words it yields
  function automatic void decode_code_byte(input logic [BYTE_W-1:0] code);
    result_t            held;
    bit                 have_held;
    bit                 hit;
    bit                 ended;
    bit                 stop;
    logic [BYTE_W-1:0]  sym;
    logic [COUNT_W-1:0] nxt;
    logic [BLEN_W-1:0]  limit;
    have_held = 1'b0;
    stop      = 1'b0;
    held      = '0;
    for (int p = 0; p < BYTE_W && !stop; p++) begin
      hit = 1'b0;
      sym = '0;
      if (lit_active) begin
        // gathering literal bits, placed by position
        lit_acc[lit_pos] = code[p];
        if (lit_pos == LAST_BIT_POS) begin
          sym        = lit_acc;
          hit        = 1'b1;
          lit_active = 1'b0;
          lit_pos    = '0;
          lit_acc    = '0;
        end else begin
          lit_pos = lit_pos + 1'b1;
        end
      end else if (code[p]) begin
        // a one ends the zero run: rank = run length
        sym     = rank_sym[run_len];
        hit     = 1'b1;
        run_len = '0;
      end else begin
        run_len = run_len + 1'b1;
        if (run_len == ESCAPE_RUN) begin
          // seven zeros open a literal
          run_len    = '0;
          lit_active = 1'b1;
          lit_pos    = '0;
          lit_acc    = '0;
        end
      end

      if (hit) begin
        nxt   = sym_done + 1'b1;
        limit = (blk_len == '0) ? BLEN_W'(1) : blk_len;   // zero length acts as one
        ended = (nxt >= limit) || (nxt == '1) || (nxt == '0);
        if (have_held) symbols_due.push_back(held);
        held.symbol       = sym;
        held.last_of_byte = 1'b0;
        held.end_of_block = ended;
        have_held         = 1'b1;
        if (ended) begin
          // block end: clean state, rest of the byte is dropped
          run_len    = '0;
          lit_active = 1'b0;
          lit_pos    = '0;
          lit_acc    = '0;
          sym_done   = '0;
          stop       = 1'b1;
        end else begin
          sym_done = nxt;
        end
      end
    end
    if (have_held) begin
      held.last_of_byte = 1'b1;
      symbols_due.push_back(held);
    end
  endfunction

  // sender: offers the oldest pending byte unless it idles this cycle
  always @(negedge clk) begin
    if (rst_n && pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
      in_push      <= 1'b1;
      in_code_byte <= pending_bytes[0];
    end else begin
      in_push      <= 1'b0;
      in_code_byte <= BYTE_W'($urandom);
    end
  end

  // receiver: random pops, none at all during the long hold
  always @(negedge clk) begin
    out_pop <= rst_n && !(rx_hold_req && !rx_hold_done) &&
               ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // long receiver hold, counted here so the sequencer carries on feeding bytes
  initial begin
    wait (rx_hold_req);
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold_done = 1'b1;
  end

  // monitor: predict on every accepted byte word, check every popped symbol word
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        void'(pending_bytes.pop_front());
        decode_code_byte(in_code_byte);
      end
      if (out_pop && !out_empty) begin
        if (symbols_due.size() == 0) begin
          report_mismatch($sformatf("symbol %02h with nothing expected", out_symbol));
        end else begin
          want = symbols_due.pop_front();
          if (out_symbol !== want.symbol)
            report_mismatch($sformatf("symbol %02h, expected %02h", out_symbol, want.symbol));
          if (out_last_of_byte !== want.last_of_byte)
            report_mismatch($sformatf("last_of_byte %b, expected %b (symbol %02h)",
                                      out_last_of_byte, want.last_of_byte, want.symbol));
          if (out_end_of_block !== want.end_of_block)
            report_mismatch($sformatf("end_of_block %b, expected %b (symbol %02h)",
                                      out_end_of_block, want.end_of_block, want.symbol));
        end
      end
    end
  end

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
  endtask

  // wait until every byte is taken and every symbol popped or the drain limit
  // runs out, then let the decoder finish any queued bytes that yield nothing
  task automatic wait_quiet();
    int n;
    n = 0;
    while ((pending_bytes.size() != 0 || symbols_due.size() != 0) && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BLEN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_BLOCK_LENGTH) blk_len = val;
    else rank_sym[idx - REG_RANK_BASE] = val[BYTE_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // build bytes from well-formed code words, with some raw and all-zero noise
  task automatic queue_coded_bytes(input int count);
    int                made;
    int                pick;
    int                rank;
    logic [BYTE_W-1:0] lit;
    logic [BYTE_W-1:0] b;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        if ($urandom_range(0, 99) < 18) begin
          // escape then a literal
          repeat (7) code_bits.push_back(1'b0);
          lit = BYTE_W'($urandom_range(0, 255));
          for (int i = 0; i < BYTE_W; i++) code_bits.push_back(lit[i]);
        end else begin
          rank = $urandom_range(0, RANK_COUNT - 1);
          repeat (rank) code_bits.push_back(1'b0);
          code_bits.push_back(1'b1);
        end
        while (code_bits.size() >= BYTE_W && made < count) begin
          for (int i = 0; i < BYTE_W; i++) b[i] = code_bits.pop_front();
          send_byte(b);
          made++;
        end
      end else if (pick < 94) begin
        send_byte(BYTE_W'($urandom));
        made++;
      end else begin
        send_byte('0);
        made++;
      end
    end
  endtask

  // sequencer
  initial begin
    logic [BLEN_W-1:0] blen_pick;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(16, 81);

    // reset values: all ranks zero, one symbol per block
    send_byte(8'hFF);
    wait_quiet();

    // distinct rank symbols, longest block so counting runs on
    cfg_write(REG_RANK_BASE + 3'd0, 20'h00000);
    cfg_write(REG_RANK_BASE + 3'd1, 20'h000FF);
    cfg_write(REG_RANK_BASE + 3'd2, 20'h0005A);
    cfg_write(REG_RANK_BASE + 3'd3, 20'h000A5);
    cfg_write(REG_RANK_BASE + 3'd4, 20'h00001);
    cfg_write(REG_RANK_BASE + 3'd5, 20'h00080);
    cfg_write(REG_RANK_BASE + 3'd6, 20'h0007E);
    cfg_write(REG_BLOCK_LENGTH, BLEN_MAX);

    send_byte(8'hFF);   // eight rank-0 symbols from one byte
    send_byte(8'h01);   // rank 0, then seven zeros: escape
    send_byte(8'hFF);   // literal ff fills the byte after the escape
    send_byte(8'h80);   // escape inside the byte, yields nothing
    send_byte(8'h00);   // literal 01 ends mid byte, zero run carries on
    send_byte(8'h02);   // rank 2, run continues
    send_byte(8'h01);   // rank 6 from a run spanning bytes, then escape
    send_byte(8'h00);   // literal 00
    send_byte(8'h28);   // rank 3 then rank 1
    send_byte(8'h08);   // rank 5 spanning bytes
    send_byte(8'h10);   // escape, then a literal that runs into the next byte
    send_byte(8'hAA);
    send_byte(8'h55);
    wait_quiet();

    // block length written below the count already reached: next symbol ends the block
    cfg_write(REG_BLOCK_LENGTH, 20'd2);
    send_byte(8'hFF);   // one symbol, rest of the byte dropped
    send_byte(8'hFF);
    send_byte(8'hFF);
    wait_quiet();

    // zero block length acts as one
    cfg_write(REG_BLOCK_LENGTH, '0);
    send_byte(8'h03);
    send_byte(8'h00);   // no symbol
    send_byte(8'hC4);
    wait_quiet();

    // random phases, each with a fresh setting of every register
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 1:    set_idling(16, 81);
        2, 3:    set_idling(81, 16);
        default: set_idling(0, 0);
      endcase
      for (int r = 0; r < RANK_COUNT; r++)
        cfg_write(REG_RANK_BASE + CFG_IDX_W'(r), BLEN_W'($urandom_range(0, BLEN_MAX)));
      case (ph)
        0:       blen_pick = BLEN_W'($urandom_range(1, 4));
        1:       blen_pick = BLEN_W'($urandom_range(5, 40));
        2:       blen_pick = BLEN_W'($urandom_range(0, BLEN_MAX));
        3:       blen_pick = BLEN_W'(1);
        4:       blen_pick = BLEN_W'($urandom_range(2, 9));
        default: blen_pick = '0;
      endcase
      cfg_write(REG_BLOCK_LENGTH, blen_pick);

      if (ph == 4) begin
        // receiver holds off while bytes keep coming: both queues fill, in_full rises
        rx_hold_req = 1'b1;
        queue_coded_bytes(PHASE_ITEMS);
      end else if (ph == 2) begin
        // sender pauses half way until every symbol is out
        queue_coded_bytes(PHASE_ITEMS / 2);
        wait_quiet();
        queue_coded_bytes(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_coded_bytes(PHASE_ITEMS);
      end
      wait_quiet();
    end

    if (symbols_due.size() != 0)
      report_mismatch($sformatf("%0d expected symbols never arrived", symbols_due.size()));
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rued_pkg.sv
sv/rued_fifo.sv
sv/rued_bit_engine.sv
sv/rank_unary_escape_decoder.sv
tb/tb_top.sv
